[design/point_cloud_mean_covariance_defines.svh]
// ---------------------------------------------------------------------------
// Point cloud mean/covariance: assertion macros
// Shared property wrappers for the block's concurrent checks.
// ---------------------------------------------------------------------------
`ifndef POINT_CLOUD_MEAN_COVARIANCE_DEFINES_SVH
`define POINT_CLOUD_MEAN_COVARIANCE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define PCMC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define PCMC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[design/pcmc_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pcmc_pkg
// Widths, queue entry type and product pair tables for the mean/covariance block.
// ---------------------------------------------------------------------------
package pcmc_pkg;

  localparam int CRD_W  = 20;  // input coordinate field
  localparam int CNT_W  = 13;  // point count
  localparam int SUM_W  = 32;  // coordinate sums
  localparam int PP_W   = 40;  // one coordinate product
  localparam int PROD_W = 52;  // product sums, with guard bit
  localparam int MEAN_W = 28;
  localparam int COV_W  = 51;
  localparam int NUM_W  = 66;  // n*Sij - Si*Sj, exact
  localparam int DEN_W  = 24;  // n*(n-1)
  localparam int DIV_W  = 72;  // scaled dividend magnitude
  localparam int HALF_W = 26;  // split of a product sum for n*Sij

  typedef struct packed {
    logic [CNT_W-1:0]            count;
    logic [2:0][SUM_W-1:0]       sum;
    logic [5:0][PROD_W-1:0]      prod;
  } acc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Coordinate pairs for xx, xy, xz, yy, yz, zz
  function automatic logic [1:0] pair_a(input logic [2:0] k);
    case (k)
      3'd0, 3'd1, 3'd2: pair_a = 2'd0;
      3'd3, 3'd4:       pair_a = 2'd1;
      default:          pair_a = 2'd2;
    endcase
  endfunction

  function automatic logic [1:0] pair_b(input logic [2:0] k);
    case (k)
      3'd0:       pair_b = 2'd0;
      3'd1, 3'd3: pair_b = 2'd1;
      default:    pair_b = 2'd2;
    endcase
  endfunction

endpackage

[design/pcmc_if.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pcmc_if
// Valid/ready channels for hits in and cluster results out.
// ---------------------------------------------------------------------------
interface pcmc_hit_if;
  logic                                valid;
  logic                                ready;
  logic signed [pcmc_pkg::CRD_W-1:0]   pos_x;
  logic signed [pcmc_pkg::CRD_W-1:0]   pos_y;
  logic signed [pcmc_pkg::CRD_W-1:0]   pos_z;
  logic                                last_hit;

  modport source (output valid, pos_x, pos_y, pos_z, last_hit, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, last_hit, output ready);
endinterface

interface pcmc_res_if;
  logic                                valid;
  logic                                ready;
  logic signed [pcmc_pkg::MEAN_W-1:0]  mean_x;
  logic signed [pcmc_pkg::MEAN_W-1:0]  mean_y;
  logic signed [pcmc_pkg::MEAN_W-1:0]  mean_z;
  logic signed [pcmc_pkg::COV_W-1:0]   cov_xx;
  logic signed [pcmc_pkg::COV_W-1:0]   cov_xy;
  logic signed [pcmc_pkg::COV_W-1:0]   cov_xz;
  logic signed [pcmc_pkg::COV_W-1:0]   cov_yy;
  logic signed [pcmc_pkg::COV_W-1:0]   cov_yz;
  logic signed [pcmc_pkg::COV_W-1:0]   cov_zz;
  logic        [pcmc_pkg::CNT_W-1:0]   point_count;
  logic                                cov_valid;

  modport source (output valid, mean_x, mean_y, mean_z, cov_xx, cov_xy, cov_xz,
                  cov_yy, cov_yz, cov_zz, point_count, cov_valid, input ready);
  modport sink   (input valid, mean_x, mean_y, mean_z, cov_xx, cov_xy, cov_xz,
                  cov_yy, cov_yz, cov_zz, point_count, cov_valid, output ready);
endinterface

[design/point_cloud_mean_covariance.sv]
`timescale 1ns / 1ps
// Throughput: one hit per cycle; the accumulator stalls only when the queue holds two clusters.
// A cluster's sums pass through the stage-one registers and enter the queue
// once the queue is not full. The solver then works out each element in turn
// with the shared one-bit-per-cycle divider, then waits for the sink.
// Reset (synchronous, rst high) clears the count, the sums, the queue and the solver.
// ---------------------------------------------------------------------------
// point_cloud_mean_covariance
// Streaming mean and sample covariance of 3D hit clusters.
// ---------------------------------------------------------------------------
`include "point_cloud_mean_covariance_defines.svh"

module point_cloud_mean_covariance #(
  parameter int MAX_POINTS = 4096,
  parameter int COORD_BITS = 20,
  parameter int FRAC_BITS  = 8
) (
  input  logic        clk,
  input  logic        rst,
  pcmc_hit_if.sink    hits,
  pcmc_res_if.source  results
);
  import pcmc_pkg::*;

  logic     push;
  logic     pop;
  acc_t     push_data;
  acc_t     head;
  q_stat_t  qstat;

  pcmc_front #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .hits      (hits),
    .qstat     (qstat),
    .push      (push),
    .push_data (push_data)
  );

  pcmc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  pcmc_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .qstat   (qstat),
    .pop     (pop),
    .results (results)
  );

  // checks
  `PCMC_ASSERT_NOW(a_no_overflow, push && !pop, !qstat.full, "push into full queue")
  `PCMC_ASSERT_NOW(a_stall_cause, !hits.ready, qstat.full, "hit stall without full queue")
  `PCMC_ASSERT_NOW(a_single_zero, results.valid && !results.cov_valid, (results.cov_xx == 0) && (results.cov_zz == 0) && (results.point_count == 1), "single point result not cleared")
  `PCMC_ASSERT_NEXT(a_pop_empty, pop, !(qstat.full && qstat.empty), "queue status inconsistent")

endmodule

[design/pcmc_front.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pcmc_front
// Accepts hits, forms products, keeps running sums and pushes a snapshot
// of the sums into the queue on the last hit of a cluster.
// ---------------------------------------------------------------------------
module pcmc_front #(
  parameter int MAX_POINTS = 4096,
  parameter int COORD_BITS = 20
) (
  input  logic              clk,
  input  logic              rst,
  pcmc_hit_if.sink          hits,
  input  pcmc_pkg::q_stat_t qstat,
  output logic              push,
  output pcmc_pkg::acc_t    push_data
);
  import pcmc_pkg::*;

  logic [CNT_W-1:0]             count;
  logic [CNT_W-1:0]             count_next;
  logic                         take;
  logic signed [CRD_W-1:0]      p [3];
  logic signed [PP_W-1:0]       pp [6];

  // stage one registers
  logic                         s1_valid;
  logic                         s1_last;
  logic                         s1_take;
  logic [CNT_W-1:0]             s1_count;
  logic signed [CRD_W-1:0]      s1_p [3];
  logic signed [PP_W-1:0]       s1_pp [6];
  logic                         s1_fire;
  logic                         accept;

  // running sums
  logic signed [SUM_W-1:0]      sum [3];
  logic signed [PROD_W-1:0]     prod [6];
  logic signed [SUM_W-1:0]      sum_next [3];
  logic signed [PROD_W-1:0]     prod_next [6];

  assign s1_fire    = s1_valid && (!s1_last || !qstat.full);
  assign hits.ready = !s1_valid || s1_fire;
  assign accept     = hits.valid && hits.ready;

  // drop coordinate bits above COORD_BITS
  always_comb begin
    p[0] = CRD_W'(signed'(hits.pos_x[COORD_BITS-1:0]));
    p[1] = CRD_W'(signed'(hits.pos_y[COORD_BITS-1:0]));
    p[2] = CRD_W'(signed'(hits.pos_z[COORD_BITS-1:0]));
    for (int k = 0; k < 6; k++) begin
      pp[k] = p[pair_a(3'(k))] * p[pair_b(3'(k))];
    end
  end

  // saturate the count at MAX_POINTS
  assign take       = count < CNT_W'(MAX_POINTS);
  assign count_next = take ? count + 1'b1 : count;

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (accept) begin
        count <= hits.last_hit ? '0 : count_next;
      end
      if (hits.ready) begin
        s1_valid <= accept;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_last  <= hits.last_hit;
      s1_take  <= take;
      s1_count <= count_next;
      s1_p     <= p;
      s1_pp    <= pp;
    end
  end

  // add the staged contribution
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum_next[k] = s1_take ? sum[k] + SUM_W'(s1_p[k]) : sum[k];
    end
    for (int k = 0; k < 6; k++) begin
      prod_next[k] = s1_take ? prod[k] + PROD_W'(s1_pp[k]) : prod[k];
    end
  end

  // accumulate, or snapshot and clear at the end of a cluster
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 3; k++) sum[k] <= '0;
      for (int k = 0; k < 6; k++) prod[k] <= '0;
    end else if (s1_fire) begin
      for (int k = 0; k < 3; k++) sum[k] <= s1_last ? '0 : sum_next[k];
      for (int k = 0; k < 6; k++) prod[k] <= s1_last ? '0 : prod_next[k];
    end
  end

  assign push = s1_fire && s1_last;

  always_comb begin
    push_data.count = s1_count;
    for (int k = 0; k < 3; k++) push_data.sum[k] = sum_next[k];
    for (int k = 0; k < 6; k++) push_data.prod[k] = prod_next[k];
  end

endmodule

[design/pcmc_queue.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pcmc_queue
// Two-entry queue of cluster sums between the accumulator and the solver.
// ---------------------------------------------------------------------------
module pcmc_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  pcmc_pkg::acc_t     push_data,
  input  logic               pop,
  output pcmc_pkg::acc_t     head,
  output pcmc_pkg::q_stat_t  qstat
);
  import pcmc_pkg::*;

  acc_t        mem [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  level;

  assign head        = mem[rd_ptr];
  assign qstat.full  = level == 2'd2;
  assign qstat.empty = level == 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      level  <= '0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   level <= level + 1'b1;
        2'b01:   level <= level - 1'b1;
        default: level <= level;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

endmodule

[design/pcmc_div.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pcmc_div
// Restoring divider, one quotient bit per cycle; keeps the low COV_W bits.
// ---------------------------------------------------------------------------
module pcmc_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [pcmc_pkg::DIV_W-1:0]  dividend,
  input  logic [pcmc_pkg::DEN_W-1:0]  divisor,
  output logic                        done,
  output logic [pcmc_pkg::COV_W-1:0]  quotient
);
  import pcmc_pkg::*;

  localparam int CW = $clog2(DIV_W + 1);

  logic             busy;
  logic [CW-1:0]    cnt;
  logic [DIV_W-1:0] dvd;
  logic [DEN_W-1:0] den;
  logic [DEN_W-1:0] rem;
  logic [DEN_W:0]   trial;
  logic             qbit;

  assign trial = {rem, dvd[DIV_W-1]};
  assign qbit  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DIV_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // shift in one dividend bit, subtract when it fits
  always_ff @(posedge clk) begin
    if (start) begin
      dvd      <= dividend;
      den      <= divisor;
      rem      <= '0;
      quotient <= '0;
    end else if (busy) begin
      dvd      <= dvd << 1;
      rem      <= qbit ? DEN_W'(trial - {1'b0, den}) : DEN_W'(trial);
      quotient <= {quotient[COV_W-2:0], qbit};
    end
  end

endmodule

[design/pcmc_back.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pcmc_back
// Pops cluster sums, works out means and covariances in turn by a shared
// divider (zero covariances for one point), holds the result for the sink.
// ---------------------------------------------------------------------------
module pcmc_back #(
  parameter int FRAC_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  pcmc_pkg::acc_t     head,
  input  pcmc_pkg::q_stat_t  qstat,
  output logic               pop,
  pcmc_res_if.source         results
);
  import pcmc_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b0000000001,
    ST_LOAD   = 10'b0000000010,
    ST_PREP   = 10'b0000000100,
    ST_MUL_LO = 10'b0000001000,
    ST_MUL_HI = 10'b0000010000,
    ST_MUL_SS = 10'b0000100000,
    ST_SUBT   = 10'b0001000000,
    ST_DIV_GO = 10'b0010000000,
    ST_DIV_WT = 10'b0100000000,
    ST_SEND   = 10'b1000000000
  } state_t;

  state_t                   state;
  acc_t                     acc;
  logic [3:0]               elem;
  logic [2:0]               cidx;
  logic [DEN_W-1:0]         den_cov;
  logic [DEN_W-1:0]         den;
  logic signed [NUM_W-1:0]  num;
  logic [NUM_W-1:0]         num_cov;
  logic [NUM_W-1:0]         mag;
  logic                     neg;
  logic [HALF_W+CNT_W-1:0]  pp_lo;
  logic signed [PP_W-1:0]   pp_hi;
  logic signed [2*SUM_W-1:0] pp_ss;
  logic signed [PROD_W-1:0] sij;
  logic signed [SUM_W-1:0]  si;
  logic signed [SUM_W-1:0]  sj;
  logic                     div_start;
  logic                     div_done;
  logic [COV_W-1:0]         div_q;
  logic [COV_W-1:0]         res;
  logic                     last_elem;
  logic signed [MEAN_W-1:0] mean_r [3];
  logic signed [COV_W-1:0]  cov_r [6];

  assign cidx      = 3'(elem - 4'd3);
  assign sij       = signed'(acc.prod[cidx]);
  assign si        = signed'(acc.sum[pair_a(cidx)]);
  assign sj        = signed'(acc.sum[pair_b(cidx)]);
  assign mag       = neg ? NUM_W'(-num) : NUM_W'(num);
  assign res       = neg ? COV_W'(-div_q) : div_q;
  assign last_elem = elem == 4'd8;
  assign pop       = state == ST_IDLE && !qstat.empty;
  assign div_start = state == ST_DIV_GO;

  // n*Sij - Si*Sj as two's complement bits
  assign num_cov   = (NUM_W'(pp_hi) <<< HALF_W) + NUM_W'(pp_lo) - NUM_W'(pp_ss);

  pcmc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (DIV_W'(mag) << FRAC_BITS),
    .divisor  (den),
    .done     (div_done),
    .quotient (div_q)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      elem  <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (!qstat.empty) state <= ST_LOAD;
        end
        ST_LOAD: begin
          elem  <= '0;
          state <= ST_PREP;
        end
        ST_PREP: begin
          if (elem < 4'd3) begin
            state <= ST_DIV_GO;
          end else if (acc.count < CNT_W'(2)) begin
            elem  <= elem + 1'b1;
            state <= last_elem ? ST_SEND : ST_PREP;
          end else begin
            state <= ST_MUL_LO;
          end
        end
        ST_MUL_LO: state <= ST_MUL_HI;
        ST_MUL_HI: state <= ST_MUL_SS;
        ST_MUL_SS: state <= ST_SUBT;
        ST_SUBT:   state <= ST_DIV_GO;
        ST_DIV_GO: state <= ST_DIV_WT;
        ST_DIV_WT: begin
          if (div_done) begin
            elem  <= elem + 1'b1;
            state <= last_elem ? ST_SEND : ST_PREP;
          end
        end
        ST_SEND: begin
          if (results.ready) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (pop) acc <= head;
    if (state == ST_LOAD) begin
      den_cov <= DEN_W'(acc.count) * (DEN_W'(acc.count) - 1'b1);
    end
    if (state == ST_PREP) begin
      if (elem < 4'd3) begin
        num <= NUM_W'(signed'(acc.sum[elem[1:0]]));
        neg <= acc.sum[elem[1:0]][SUM_W-1];
        den <= DEN_W'(acc.count);
      end else if (acc.count < CNT_W'(2)) begin
        cov_r[cidx] <= '0;
      end else begin
        den <= den_cov;
      end
    end
    if (state == ST_MUL_LO) pp_lo <= acc.count * sij[HALF_W-1:0];
    if (state == ST_MUL_HI) begin
      pp_hi <= signed'({1'b0, acc.count}) * signed'(sij[PROD_W-1:HALF_W]);
    end
    if (state == ST_MUL_SS) pp_ss <= si * sj;
    if (state == ST_SUBT) begin
      num <= signed'(num_cov);
      neg <= num_cov[NUM_W-1];
    end
    if (state == ST_DIV_WT && div_done) begin
      if (elem < 4'd3) begin
        mean_r[elem[1:0]] <= MEAN_W'(res);
      end else begin
        cov_r[cidx] <= res;
      end
    end
  end

  assign results.valid       = state == ST_SEND;
  assign results.mean_x      = mean_r[0];
  assign results.mean_y      = mean_r[1];
  assign results.mean_z      = mean_r[2];
  assign results.cov_xx      = cov_r[0];
  assign results.cov_xy      = cov_r[1];
  assign results.cov_xz      = cov_r[2];
  assign results.cov_yy      = cov_r[3];
  assign results.cov_yz      = cov_r[4];
  assign results.cov_zz      = cov_r[5];
  assign results.point_count = acc.count;
  assign results.cov_valid   = acc.count >= CNT_W'(2);

endmodule
